>>> src/spsum_pkg.sv
package spsum_pkg;

  // register indexes of the configuration port
  localparam logic REG_SOFTENING  = 1'b0;
  localparam logic REG_BODY_COUNT = 1'b1;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [31:0] SOFTENING_RESET = 32'd26214400;

  // operations of the shared root / divide unit
  typedef enum logic {
    OP_ROOT   = 1'b0,
    OP_DIVIDE = 1'b1
  } unit_op_e;

  typedef struct packed {
    logic        cmd;
    logic [5:0]  body_index;
    logic [23:0] body_mass;
    logic signed [23:0] body_x;
    logic signed [23:0] body_y;
    logic signed [23:0] body_z;
    logic signed [23:0] point_x;
    logic signed [23:0] point_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] potential;
    logic               saturated;
  } out_word_t;

  // request from the sequencer to the shared unit
  typedef struct packed {
    logic        start;
    unit_op_e    op;
    logic [61:0] operand;  // radicand, or dividend left aligned
    logic [30:0] divisor;
  } unit_req_t;

  typedef struct packed {
    logic        busy;
    logic [46:0] result;
  } unit_rsp_t;

endpackage

>>> src/spsum_ram.sv
module spsum_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/spsum_unit.sv
module spsum_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  spsum_pkg::unit_req_t req_i,
  output spsum_pkg::unit_rsp_t rsp_o
);

  localparam logic [5:0] ROOT_STEPS = 6'd31;
  localparam logic [5:0] DIV_STEPS  = 6'd47;

  logic                busy_q, busy_d;
  logic [5:0]          cnt_q, cnt_d;
  spsum_pkg::unit_op_e op_q, op_d;
  logic [61:0]         src_q, src_d;
  logic [34:0]         rem_q, rem_d;
  logic [46:0]         res_q, res_d;
  logic [30:0]         den_q, den_d;
  logic [34:0]         trial_a, trial_b;
  logic [35:0]         diff;
  logic                fits;

  // one shared compare and subtract: root digit or quotient bit
  always_comb begin
    if (op_q == spsum_pkg::OP_ROOT) begin
      trial_a = {rem_q[32:0], src_q[61:60]};
      trial_b = {res_q[32:0], 2'b01};
    end else begin
      trial_a = {rem_q[33:0], src_q[61]};
      trial_b = {4'b0, den_q};
    end
    diff = {1'b0, trial_a} - {1'b0, trial_b};
    fits = !diff[35];
  end

  // sequencing of the iterations
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    op_d   = op_q;
    src_d  = src_q;
    rem_d  = rem_q;
    res_d  = res_q;
    den_d  = den_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      src_d  = req_i.operand;
      den_d  = req_i.divisor;
      rem_d  = '0;
      res_d  = '0;
      cnt_d  = (req_i.op == spsum_pkg::OP_ROOT) ? ROOT_STEPS : DIV_STEPS;
    end else if (busy_q) begin
      rem_d = fits ? diff[34:0] : trial_a;
      res_d = {res_q[45:0], fits};
      src_d = (op_q == spsum_pkg::OP_ROOT) ? {src_q[59:0], 2'b00} : {src_q[60:0], 1'b0};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    src_q <= src_d;
    rem_q <= rem_d;
    res_q <= res_d;
    den_q <= den_d;
  end

  assign rsp_o.busy   = busy_q;
  assign rsp_o.result = res_q;

`ifndef SYNTHESIS
  a_cnt_live : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != 6'd0)
    else $error("shared unit busy with no steps left");
  a_div_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.start && !busy_q && req_i.op == spsum_pkg::OP_DIVIDE) |-> req_i.divisor != '0)
    else $error("division started with a zero divisor");
  a_busy_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.start && !busy_q) |=> busy_q)
    else $error("shared unit did not start");
`endif

endmodule

>>> src/softened_potential_sum.sv
// Softened potential sum. A write word (cmd 0) stores one body entry and gives no result.
// A query word (cmd 1) returns minus the sum over the first body_count entries of
// 2^16 * mass / sqrt(r^2 + softening), saturated to -2^31 with the flag set. Queries run
// through one shared iterative unit. Each body goes through a table read, squaring and
// summing on one multiplier, a start and finish of the 31-step square root, a start and
// finish of the 47-step division (skipped when the root is zero), and a step on. The
// result word of a query is valid once every body is done, and later if the result side
// still holds off a previous word; the input is not ready meanwhile. Configuration writes
// are taken at any time and must only be made while the block is idle.
module softened_potential_sum #(
  parameter int MAX_BODIES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  spsum_pkg::in_word_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output spsum_pkg::out_word_t out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  localparam int AW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
  localparam int CW = $clog2(MAX_BODIES + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_READ = 4'd1;
  localparam logic [3:0] S_SQX  = 4'd2;
  localparam logic [3:0] S_SQY  = 4'd3;
  localparam logic [3:0] S_SQZ  = 4'd4;
  localparam logic [3:0] S_SUM  = 4'd5;
  localparam logic [3:0] S_ROOT = 4'd6;
  localparam logic [3:0] S_RWT  = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_DWT  = 4'd9;
  localparam logic [3:0] S_ACC  = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;

  logic [3:0]  state_q, state_d;
  logic [31:0] soft_q;
  logic [6:0]  count_q;
  logic [CW-1:0] n_q, n_d, i_q, i_d;
  logic signed [23:0] px_q, px_d, pz_q, pz_d;
  logic [49:0] dist_q, dist_d;
  logic [47:0] sq_q, sq_d;
  logic [31:0] total_q, total_d;
  logic        big_q, big_d, inf_q, inf_d;
  logic        out_valid_q, out_valid_d;
  spsum_pkg::out_word_t out_q, out_d;

  logic        in_acc, ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [95:0] ram_rdata;
  logic [23:0] t_mass;
  logic signed [23:0] t_x, t_y, t_z;
  logic signed [23:0] mul_a, mul_b;
  logic signed [24:0] diff;
  logic [23:0] mag;
  logic [47:0] sum;
  logic [30:0] root;
  spsum_pkg::unit_req_t ureq;
  spsum_pkg::unit_rsp_t ursp;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      soft_q  <= spsum_pkg::SOFTENING_RESET;
      count_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        spsum_pkg::REG_SOFTENING:  soft_q  <= cfg_data_i;
        spsum_pkg::REG_BODY_COUNT: count_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // body table: mass, x, y, z in one word
  assign ram_we    = in_acc && (in_data_i.cmd == spsum_pkg::CMD_WRITE)
                     && (32'(in_data_i.body_index) < MAX_BODIES);
  assign ram_waddr = AW'(in_data_i.body_index);
  assign ram_re    = (state_q == S_READ);

  spsum_ram #(.WIDTH(96), .DEPTH(MAX_BODIES)) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({in_data_i.body_mass, in_data_i.body_x, in_data_i.body_y, in_data_i.body_z}),
    .re_i    (ram_re),
    .raddr_i (i_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign t_mass = ram_rdata[95:72];
  assign t_x    = ram_rdata[71:48];
  assign t_y    = ram_rdata[47:24];
  assign t_z    = ram_rdata[23:0];

  // shared squaring multiplier on the coordinate difference
  always_comb begin
    case (state_q)
      S_SQX:   begin mul_a = t_x; mul_b = px_q; end
      S_SQY:   begin mul_a = t_y; mul_b = '0;   end
      default: begin mul_a = t_z; mul_b = pz_q; end
    endcase
    diff = 25'(mul_a) - 25'(mul_b);
    mag  = diff[24] ? 24'(-diff) : diff[23:0];
  end

  assign root = ursp.result[30:0];
  assign sum  = {16'b0, total_q} + {1'b0, ursp.result};

  // sequencer
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    i_d         = i_q;
    px_d        = px_q;
    pz_d        = pz_q;
    dist_d      = dist_q;
    sq_d        = sq_q;
    total_d     = total_q;
    big_d       = big_q;
    inf_d       = inf_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    ureq.start   = 1'b0;
    ureq.op      = spsum_pkg::OP_ROOT;
    ureq.operand = {dist_q, 12'b0};
    ureq.divisor = root;
    case (state_q)
      S_IDLE: begin
        if (in_acc && in_data_i.cmd == spsum_pkg::CMD_QUERY) begin
          px_d    = in_data_i.point_x;
          pz_d    = in_data_i.point_z;
          n_d     = (32'(count_q) > MAX_BODIES) ? CW'(MAX_BODIES) : CW'(count_q);
          i_d     = '0;
          total_d = '0;
          big_d   = 1'b0;
          inf_d   = 1'b0;
          state_d = (count_q == '0) ? S_FIN : S_READ;
        end
      end
      S_READ: state_d = S_SQX;
      S_SQX: begin
        sq_d    = mag * mag;
        state_d = S_SQY;
      end
      S_SQY: begin
        sq_d    = mag * mag;
        dist_d  = 50'(soft_q) + 50'(sq_q);
        state_d = S_SQZ;
      end
      S_SQZ: begin
        sq_d    = mag * mag;
        dist_d  = dist_q + 50'(sq_q);
        state_d = S_SUM;
      end
      S_SUM: begin
        dist_d  = dist_q + 50'(sq_q);
        state_d = S_ROOT;
      end
      S_ROOT: begin
        ureq.start = 1'b1;
        state_d    = S_RWT;
      end
      S_RWT: begin
        if (!ursp.busy) begin
          if (root == '0) begin
            if (t_mass != '0) inf_d = 1'b1;
            state_d = S_ACC;
          end else begin
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        ureq.start   = 1'b1;
        ureq.op      = spsum_pkg::OP_DIVIDE;
        ureq.operand = {47'({t_mass, 22'b0}) + 47'(root[30:1]), 15'b0};
        state_d      = S_DWT;
      end
      S_DWT: begin
        if (!ursp.busy) begin
          if (sum[47:32] != '0) big_d = 1'b1;
          total_d = sum[31:0];
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        i_d     = i_q + CW'(1);
        state_d = (i_q + CW'(1) == n_q) ? S_FIN : S_READ;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (inf_q || big_q || total_q > 32'h8000_0000) begin
            out_d.potential = 32'sh8000_0000;
            out_d.saturated = 1'b1;
          end else begin
            out_d.potential = -$signed(total_q);
            out_d.saturated = 1'b0;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  spsum_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ureq),
    .rsp_o  (ursp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      i_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      n_q         <= n_d;
      i_q         <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q    <= px_d;
    pz_q    <= pz_d;
    dist_q  <= dist_d;
    sq_q    <= sq_d;
    total_q <= total_d;
    big_q   <= big_d;
    inf_q   <= inf_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_query_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.cmd == spsum_pkg::CMD_QUERY) |=> !in_ready_o)
    else $error("query accepted but block still ready");
  a_index_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> i_q < n_q)
    else $error("body index past the count");
  a_sat_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.saturated) |-> out_data_o.potential == 32'sh8000_0000)
    else $error("saturated word with an unclipped potential");
  a_start_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ureq.start |-> !ursp.busy)
    else $error("shared unit started while busy");
`endif

endmodule

>>> sim/tb_softened_potential_sum.sv
module tb_softened_potential_sum;

  localparam int          TABLE_DEPTH = 64;
  localparam int          CYCLE_LIMIT = 12000000;
  localparam logic [31:0] SOFT_MAX    = 32'hFFFF_FFFF;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  spsum_pkg::in_word_t  in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  spsum_pkg::out_word_t out_data_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic                 cfg_index_i;
  logic [31:0]          cfg_data_i;

  softened_potential_sum u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // predictor state: own copy of the body table and registers
  logic [23:0] mass_mem [TABLE_DEPTH];
  logic [23:0] xpos_mem [TABLE_DEPTH];
  logic [23:0] ypos_mem [TABLE_DEPTH];
  logic [23:0] zpos_mem [TABLE_DEPTH];
  bit          entry_written [TABLE_DEPTH];
  logic [31:0] soft_reg;
  logic [6:0]  count_reg;

  spsum_pkg::out_word_t potential_q [$];
  int unsigned mismatches;
  int unsigned words_sent;
  int unsigned queries_sent;
  int unsigned results_seen;
  int unsigned saturated_seen;
  int unsigned cycle_count;
  bit          calm;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned axis_square(input logic [23:0] a, input longint p);
    longint d;
    d = longint'(signed'(a)) - p;
    if (d < 0) d = -d;
    return longint'(d) * longint'(d);
  endfunction

  // softened potential at (px, 0, pz) over the first count_reg bodies
  function automatic spsum_pkg::out_word_t potential_at(input logic [23:0] px,
                                                        input logic [23:0] pz);
    spsum_pkg::out_word_t r;
    longint unsigned total;
    longint unsigned dist_sq;
    longint unsigned root;
    longint unsigned num;
    bit              blown;
    int              n;
    total = 0;
    blown = 0;
    n = (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : count_reg;
    for (int i = 0; i < n; i++) begin
      dist_sq = axis_square(xpos_mem[i], longint'(signed'(px))) + axis_square(ypos_mem[i], 0)
              + axis_square(zpos_mem[i], longint'(signed'(pz))) + longint'(soft_reg);
      root = floor_root(dist_sq << 12);
      num  = longint'(mass_mem[i]) << 22;
      if (root == 0) begin
        if (num != 0) blown = 1;
      end else begin
        total += (num + (root >> 1)) / root;
      end
    end
    if (blown || total > (64'd1 << 31)) begin
      r.potential = 32'sh8000_0000;
      r.saturated = 1'b1;
    end else begin
      r.potential = 32'(-total);
      r.saturated = 1'b0;
    end
    return r;
  endfunction

  function automatic int written_prefix();
    int n;
    n = 0;
    while (n < TABLE_DEPTH && entry_written[n]) n++;
    return n;
  endfunction

  // send one word and update the predictor when it is taken
  task automatic send_word(input spsum_pkg::in_word_t w);
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    if (w.cmd == spsum_pkg::CMD_WRITE) begin
      mass_mem[w.body_index]      = w.body_mass;
      xpos_mem[w.body_index]      = w.body_x;
      ypos_mem[w.body_index]      = w.body_y;
      zpos_mem[w.body_index]      = w.body_z;
      entry_written[w.body_index] = 1'b1;
    end else begin
      queries_sent++;
      potential_q.push_back(potential_at(w.point_x, w.point_z));
    end
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  function automatic spsum_pkg::in_word_t body_word(input int idx, input logic [23:0] m,
                                                    input logic [23:0] x, input logic [23:0] y,
                                                    input logic [23:0] z);
    spsum_pkg::in_word_t w;
    logic [191:0]        noise;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    w = noise[$bits(spsum_pkg::in_word_t)-1:0];
    w.cmd = spsum_pkg::CMD_WRITE;
    w.body_index = idx[5:0];
    w.body_mass = m;
    w.body_x = x;
    w.body_y = y;
    w.body_z = z;
    return w;
  endfunction

  function automatic spsum_pkg::in_word_t point_word(input logic [23:0] x,
                                                     input logic [23:0] z);
    spsum_pkg::in_word_t w;
    logic [191:0]        noise;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    w = noise[$bits(spsum_pkg::in_word_t)-1:0];
    w.cmd = spsum_pkg::CMD_QUERY;
    w.point_x = x;
    w.point_z = z;
    return w;
  endfunction

  // wait until the block has nothing in flight
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (potential_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == spsum_pkg::REG_SOFTENING) soft_reg = data;
    else count_reg = data[6:0];
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    spsum_pkg::out_word_t exp_w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (out_data_o.saturated) saturated_seen++;
      if (potential_q.size() == 0) begin
        report($sformatf("unexpected result %h", out_data_o));
      end else begin
        exp_w = potential_q.pop_front();
        if (out_data_o.potential !== exp_w.potential)
          report($sformatf("potential %h, want %h", out_data_o.potential, exp_w.potential));
        if (out_data_o.saturated !== exp_w.saturated)
          report($sformatf("saturated %b, want %b", out_data_o.saturated, exp_w.saturated));
      end
    end
  end

  // result side back-pressure
  initial begin
    @(posedge rst_ni);
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      if (!calm) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  function automatic logic [23:0] rand_coord();
    if ($urandom_range(0, 1) == 0) return 24'($signed($urandom_range(0, 8191)) - 4096);
    return 24'($urandom);
  endfunction

  // extremes of masses and positions, count zero, reset softening
  task automatic test_extremes();
    send_word(point_word(24'h7FFFFF, 24'h800000));
    send_word(body_word(0, 24'hFFFFFF, 24'h000000, 24'h000000, 24'h000000));
    send_word(body_word(1, 24'h000000, 24'h7FFFFF, 24'h000000, 24'h7FFFFF));
    send_word(body_word(2, 24'h000001, 24'h800000, 24'h800000, 24'h800000));
    send_word(body_word(3, 24'($urandom), rand_coord(), rand_coord(), rand_coord()));
    wait_idle();
    write_reg(spsum_pkg::REG_BODY_COUNT, 32'd4);
    send_word(point_word(24'h000000, 24'h000000));
    send_word(point_word(24'h7FFFFF, 24'h7FFFFF));
    send_word(point_word(24'h800000, 24'h800000));
    send_word(point_word(24'h800000, 24'h7FFFFF));
  endtask

  // zero distance with zero softening, massless body at zero distance, tiny and huge softening
  task automatic test_special_cases();
    wait_idle();
    write_reg(spsum_pkg::REG_SOFTENING, 32'd0);
    send_word(point_word(24'h000000, 24'h000000));
    send_word(point_word(24'h7FFFFF, 24'h7FFFFF));
    send_word(point_word(24'h000100, 24'h000000));
    wait_idle();
    write_reg(spsum_pkg::REG_BODY_COUNT, 32'd2);
    send_word(point_word(24'h7FFFFF, 24'h7FFFFF));
    wait_idle();
    write_reg(spsum_pkg::REG_SOFTENING, 32'd1);
    send_word(point_word(24'h000000, 24'h000001));
    wait_idle();
    write_reg(spsum_pkg::REG_SOFTENING, SOFT_MAX);
    write_reg(spsum_pkg::REG_BODY_COUNT, 32'd4);
    send_word(point_word(24'h000000, 24'h000000));
    send_word(point_word(24'h800000, 24'h7FFFFF));
  endtask

  // phases of random bodies and queries under changing registers
  task automatic test_random_phases(input int unsigned stop_at);
    int          avail;
    int          idx;
    logic [31:0] soft_val;
    logic [6:0]  cnt;
    while (words_sent < stop_at) begin
      wait_idle();
      case ($urandom_range(0, 4))
        0: soft_val = 32'd0;
        1: soft_val = SOFT_MAX;
        2: soft_val = spsum_pkg::SOFTENING_RESET;
        3: soft_val = $urandom_range(0, 4096);
        default: soft_val = $urandom;
      endcase
      avail = written_prefix();
      if (avail == TABLE_DEPTH && $urandom_range(0, 4) == 0)
        cnt = 7'($urandom_range(TABLE_DEPTH, 127));
      else if ($urandom_range(0, 3) == 0)
        cnt = 7'($urandom_range(0, avail));
      else
        cnt = 7'($urandom_range(0, (avail < 8) ? avail : 8));
      write_reg(spsum_pkg::REG_SOFTENING, soft_val);
      write_reg(spsum_pkg::REG_BODY_COUNT, 32'(cnt));
      repeat ($urandom_range(15, 30)) begin
        if ($urandom_range(0, 1) == 0) begin
          avail = written_prefix();
          if (avail < TABLE_DEPTH && $urandom_range(0, 9) < 7) idx = avail;
          else idx = $urandom_range(0, TABLE_DEPTH - 1);
          send_word(body_word(idx, 24'($urandom), rand_coord(), rand_coord(), rand_coord()));
        end else begin
          send_word(point_word(rand_coord(), rand_coord()));
        end
      end
    end
  endtask

  // final stretch with no idling on either side
  task automatic test_calm_tail();
    wait_idle();
    calm = 1'b1;
    test_random_phases(words_sent + 30);
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_ready_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= spsum_pkg::REG_SOFTENING;
    cfg_data_i  <= '0;
    soft_reg    = spsum_pkg::SOFTENING_RESET;
    count_reg   = '0;
    calm        = 1'b0;
    mismatches  = 0;
    cycle_count = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      mass_mem[i] = '0;
      xpos_mem[i] = '0;
      ypos_mem[i] = '0;
      zpos_mem[i] = '0;
      entry_written[i] = 1'b0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_special_cases();
    test_random_phases(260);
    test_calm_tail();

    wait_idle();
    repeat (100) @(posedge clk_i);
    $display("sent %0d words (%0d queries); checked %0d potentials, %0d saturated",
             words_sent, queries_sent, results_seen, saturated_seen);
    $display("table fill reached %0d entries, %0d mismatches", written_prefix(), mismatches);
    if (mismatches == 0 && potential_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/spsum_pkg.sv
src/spsum_ram.sv
src/spsum_unit.sv
src/softened_potential_sum.sv
sim/tb_softened_potential_sum.sv
